@@ rtl/core/rsi_pkg.sv @@
// shared types, constants and helper functions of the ray-sphere intersection core
package rsi_pkg;

  // fixed point format
  localparam int RSI_FRAC_BITS = 16;
  localparam int RSI_DATA_W    = 32;
  localparam int RSI_RAD_W     = 31;

  // wide intermediate widths
  localparam int RSI_PROD_W = 64;
  localparam int RSI_DISC_W = 128;
  localparam int RSI_ROOT_W = RSI_DISC_W / 2;
  localparam int RSI_QUOT_W = 31;

  // configuration port
  localparam int RSI_CFG_IDX_W = 2;

  typedef enum logic [RSI_CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_t;

  typedef logic signed [RSI_DATA_W-1:0] fix_t;
  typedef fix_t [2:0] vec3_t;

  localparam fix_t FIX_MAX = fix_t'(32'h7fff_ffff);
  localparam fix_t FIX_MIN = fix_t'(32'h8000_0000);

  // one ray
  typedef struct packed {
    vec3_t start;
    vec3_t dir;
  } ray_t;

  // quadratic terms carried alongside the square root
  typedef struct packed {
    logic [RSI_PROD_W-1:0] hm;
    logic [RSI_PROD_W-1:0] a;
    logic                  h_neg;
    logic                  c_neg;
    logic                  c_zero;
    logic                  hit;
    vec3_t                 start;
    vec3_t                 dir;
  } quad_t;

  // ray data carried alongside the distance divide
  typedef struct packed {
    logic  hit;
    vec3_t start;
    vec3_t dir;
  } ray_side_t;

  // hit data carried alongside the normal divide
  typedef struct packed {
    logic       hit;
    fix_t       hit_dist;
    vec3_t      pos;
    logic [2:0] neg;
  } norm_side_t;

  // saturate a wide signed value to 32 bits
  function automatic fix_t sat32(input logic signed [65:0] v);
    fix_t r;
    if (v > 66'(FIX_MAX)) begin
      r = FIX_MAX;
    end else if (v < 66'(FIX_MIN)) begin
      r = FIX_MIN;
    end else begin
      r = v[RSI_DATA_W-1:0];
    end
    return r;
  endfunction

  // magnitude of a signed 32 bit value
  function automatic logic [RSI_DATA_W-1:0] umag(input fix_t v);
    logic [RSI_DATA_W-1:0] r;
    r = v[RSI_DATA_W-1] ? RSI_DATA_W'(-v) : RSI_DATA_W'(v);
    return r;
  endfunction

endpackage

@@ rtl/core/rsi_if.sv @@
// ray request and hit request channel interfaces
interface rsi_ray_if import rsi_pkg::*; ();
  logic valid;
  logic ready;
  fix_t start_x;
  fix_t start_y;
  fix_t start_z;
  fix_t dir_x;
  fix_t dir_y;
  fix_t dir_z;

  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_hit_if import rsi_pkg::*; ();
  logic valid;
  logic ready;
  logic hit_found;
  fix_t hit_distance;
  fix_t pos_x;
  fix_t pos_y;
  fix_t pos_z;
  fix_t norm_x;
  fix_t norm_y;
  fix_t norm_z;

  modport source (output valid, hit_found, hit_distance, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, input ready);
  modport sink   (input valid, hit_found, hit_distance, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, output ready);
endinterface

@@ rtl/core/rsi_front.sv @@
// front end: offsets, dot products and discriminant over seven stages
module rsi_front import rsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  ray_t                  in_ray,
  input  vec3_t                 center,
  input  logic [RSI_RAD_W-1:0]  radius,
  output logic                  out_valid,
  output quad_t                 out_side,
  output logic [RSI_DISC_W-1:0] out_disc
);

  localparam int PW = RSI_PROD_W;
  localparam int HW = PW / 2;
  localparam int DW = RSI_DISC_W;
  localparam int R2W = 2 * RSI_RAD_W;

  logic [6:0] vld;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // stage 1: saturated offset from the center
  vec3_t s1_start, s1_dir, s1_off;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_start <= in_ray.start;
      s1_dir   <= in_ray.dir;
      for (int i = 0; i < 3; i++) begin
        s1_off[i] <= sat32(66'($signed(in_ray.start[i])) - 66'($signed(center[i])));
      end
    end
  end

  // stage 2: component products and radius square
  logic [PW-1:0]  s2_dd [3];
  logic [PW-1:0]  s2_oo [3];
  logic [PW-1:0]  s2_od [3];
  logic [2:0]     s2_sd;
  logic [R2W-1:0] s2_r2;
  vec3_t          s2_start, s2_dir;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_start <= s1_start;
      s2_dir   <= s1_dir;
      s2_r2    <= radius * radius;
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= umag(s1_dir[i]) * umag(s1_dir[i]);
        s2_oo[i] <= umag(s1_off[i]) * umag(s1_off[i]);
        s2_od[i] <= umag(s1_off[i]) * umag(s1_dir[i]);
        s2_sd[i] <= s1_off[i][RSI_DATA_W-1] ^ s1_dir[i][RSI_DATA_W-1];
      end
    end
  end

  // stage 3: sums of products, h split by sign
  logic [PW-1:0]  hp_sum, hn_sum;
  logic [PW-1:0]  s3_a, s3_sum2, s3_hpos, s3_hneg;
  logic [R2W-1:0] s3_r2;
  vec3_t          s3_start, s3_dir;

  always_comb begin
    hp_sum = '0;
    hn_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (s2_sd[i]) begin
        hn_sum = hn_sum + s2_od[i];
      end else begin
        hp_sum = hp_sum + s2_od[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a     <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_sum2  <= s2_oo[0] + s2_oo[1] + s2_oo[2];
      s3_hpos  <= hp_sum;
      s3_hneg  <= hn_sum;
      s3_r2    <= s2_r2;
      s3_start <= s2_start;
      s3_dir   <= s2_dir;
    end
  end

  // stage 4: signs and magnitudes of h and c
  logic          s4_h_neg, s4_c_neg, s4_c_zero, s4_a_nz;
  logic [PW-1:0] s4_hm, s4_cm, s4_a;
  vec3_t         s4_start, s4_dir;
  logic [PW-1:0] r2_w;

  assign r2_w = PW'(s3_r2);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_h_neg  <= s3_hneg > s3_hpos;
      s4_hm     <= (s3_hneg > s3_hpos) ? s3_hneg - s3_hpos : s3_hpos - s3_hneg;
      s4_c_neg  <= s3_sum2 < r2_w;
      s4_c_zero <= s3_sum2 == r2_w;
      s4_cm     <= (s3_sum2 < r2_w) ? r2_w - s3_sum2 : s3_sum2 - r2_w;
      s4_a      <= s3_a;
      s4_a_nz   <= s3_a != '0;
      s4_start  <= s3_start;
      s4_dir    <= s3_dir;
    end
  end

  // stage 5: 32 bit partial products of h*h and a*c
  logic [PW-1:0] s5_hh_ll, s5_hh_lh, s5_hh_hh;
  logic [PW-1:0] s5_ac_ll, s5_ac_lh, s5_ac_hl, s5_ac_hh;
  logic          s5_h_neg, s5_c_neg, s5_c_zero, s5_a_nz;
  logic [PW-1:0] s5_hm, s5_a;
  vec3_t         s5_start, s5_dir;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hh_ll  <= s4_hm[HW-1:0]  * s4_hm[HW-1:0];
      s5_hh_lh  <= s4_hm[HW-1:0]  * s4_hm[PW-1:HW];
      s5_hh_hh  <= s4_hm[PW-1:HW] * s4_hm[PW-1:HW];
      s5_ac_ll  <= s4_a[HW-1:0]   * s4_cm[HW-1:0];
      s5_ac_lh  <= s4_a[HW-1:0]   * s4_cm[PW-1:HW];
      s5_ac_hl  <= s4_a[PW-1:HW]  * s4_cm[HW-1:0];
      s5_ac_hh  <= s4_a[PW-1:HW]  * s4_cm[PW-1:HW];
      s5_h_neg  <= s4_h_neg;
      s5_c_neg  <= s4_c_neg;
      s5_c_zero <= s4_c_zero;
      s5_a_nz   <= s4_a_nz;
      s5_hm     <= s4_hm;
      s5_a      <= s4_a;
      s5_start  <= s4_start;
      s5_dir    <= s4_dir;
    end
  end

  // stage 6: combine partial products
  logic [DW-1:0] s6_hh, s6_ac;
  logic          s6_h_neg, s6_c_neg, s6_c_zero, s6_a_nz;
  logic [PW-1:0] s6_hm, s6_a;
  vec3_t         s6_start, s6_dir;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_hh <= {s5_hh_hh, {PW{1'b0}}} + (DW'(s5_hh_lh) << (HW + 1)) + DW'(s5_hh_ll);
      s6_ac <= {s5_ac_hh, {PW{1'b0}}} + (DW'(s5_ac_lh) << HW) + (DW'(s5_ac_hl) << HW)
               + DW'(s5_ac_ll);
      s6_h_neg  <= s5_h_neg;
      s6_c_neg  <= s5_c_neg;
      s6_c_zero <= s5_c_zero;
      s6_a_nz   <= s5_a_nz;
      s6_hm     <= s5_hm;
      s6_a      <= s5_a;
      s6_start  <= s5_start;
      s6_dir    <= s5_dir;
    end
  end

  // stage 7: discriminant and hit decision
  logic ac_le_hh;

  assign ac_le_hh = s6_ac <= s6_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      out_disc        <= s6_c_neg ? s6_hh + s6_ac : s6_hh - s6_ac;
      out_side.hit    <= s6_a_nz && (s6_c_neg || (ac_le_hh && s6_h_neg));
      out_side.hm     <= s6_hm;
      out_side.a      <= s6_a;
      out_side.h_neg  <= s6_h_neg;
      out_side.c_neg  <= s6_c_neg;
      out_side.c_zero <= s6_c_zero;
      out_side.start  <= s6_start;
      out_side.dir    <= s6_dir;
    end
  end

  assign out_valid = vld[6];

endmodule

@@ rtl/core/rsi_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module rsi_sqrt import rsi_pkg::*; #(
  parameter type SIDE_T = logic
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RSI_DISC_W-1:0] in_rad,
  input  SIDE_T                 in_side,
  output logic                  out_valid,
  output logic [RSI_ROOT_W-1:0] out_root,
  output SIDE_T                 out_side
);

  localparam int DW    = RSI_DISC_W;
  localparam int RW    = RSI_ROOT_W;
  localparam int REM_W = RW + 4;

  logic [RW:0]       vld;
  logic [REM_W-1:0]  rem  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [DW-1:0]     dsh  [RW+1];
  SIDE_T             side [RW+1];

  // stage 0 is the input
  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign dsh[0]  = in_rad;
  assign side[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REM_W-1:0] rin, trial;
    logic             take;

    // bring down two radicand bits and try the next root bit
    assign rin   = {rem[k][REM_W-3:0], dsh[k][DW-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign take  = rin >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rin - trial : rin;
        root[k+1] <= {root[k][RW-2:0], take};
        dsh[k+1]  <= dsh[k] << 2;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

@@ rtl/core/rsi_div.sv @@
// pipelined saturating restoring divider, one quotient bit per stage
module rsi_div import rsi_pkg::*; #(
  parameter int  NUM_W = 82,
  parameter int  DEN_W = 64,
  parameter int  Q_W   = RSI_QUOT_W,
  parameter int  LANES = 1,
  parameter type SIDE_T = logic
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num [LANES],
  input  logic [DEN_W-1:0] in_den,
  input  SIDE_T            in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_q   [LANES],
  output logic             out_sat [LANES],
  output SIDE_T            out_side
);

  localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [Q_W:0]     vld;
  logic [W-1:0]     rem [Q_W+1][LANES];
  logic [Q_W-1:0]   quo [Q_W+1][LANES];
  logic             sat [Q_W+1][LANES];
  logic [DEN_W-1:0] den [Q_W+1];
  SIDE_T            side [Q_W+1];

  // stage 0: overflow check against den * 2^Q_W
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= in_den;
      side[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= W'(in_num[l]);
        quo[0][l] <= '0;
        sat[0][l] <= W'(in_num[l]) >= (W'(in_den) << Q_W);
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [W-1:0] dsh;

    // divisor aligned to this quotient bit
    assign dsh = W'(den[k]) << (Q_W - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
        for (int l = 0; l < LANES; l++) begin
          rem[k+1][l] <= (rem[k][l] >= dsh) ? rem[k][l] - dsh : rem[k][l];
          quo[k+1][l] <= {quo[k][l][Q_W-2:0], rem[k][l] >= dsh};
          sat[k+1][l] <= sat[k][l];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_side  = side[Q_W];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_q[l]   = quo[Q_W][l];
    assign out_sat[l] = sat[Q_W][l];
  end

endmodule

@@ rtl/core/ray_sphere_intersect_core.sv @@
// Ray-sphere intersection core. Takes one ray (origin, direction) per request and
// returns one hit request against the sphere set in the configuration registers
// (center_x/y/z at index 0..2, sphere_radius at index 3). All values are fixed point
// with FRAC_BITS fraction bits, signed but for the unsigned 31-bit radius. A ray is
// accepted every cycle while the output is free or being taken; results return in
// order. Most of the pipeline is the 64-stage square root of the 128-bit
// discriminant and the two 32-stage dividers (distance, then the three normal
// components in parallel). The whole pipeline holds while a finished result waits
// on hit.ready. Misses return hit_found = 0, distance -1.0 and zero position and normal.
module ray_sphere_intersect_core import rsi_pkg::*; #(
  parameter int FRAC_BITS = RSI_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [RSI_CFG_IDX_W-1:0] cfg_index,
  input  logic [RSI_DATA_W-1:0]    cfg_data,
  rsi_ray_if.sink                  ray,
  rsi_hit_if.source                hit
);

  localparam int PW    = RSI_PROD_W;
  localparam int RW    = RSI_ROOT_W;
  localparam int QW    = RSI_QUOT_W;
  localparam int NUM_W = RW + 2 + FRAC_BITS;
  localparam int NRM_W = RSI_DATA_W + 1 + FRAC_BITS;

  localparam logic [RSI_RAD_W-1:0] RAD_ONE   = RSI_RAD_W'(1) << FRAC_BITS;
  localparam fix_t                 DIST_MISS = -(fix_t'(1) <<< FRAC_BITS);

  // configuration registers
  vec3_t                center;
  logic [RSI_RAD_W-1:0] radius;
  logic [RSI_RAD_W-1:0] rad_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      radius <= RAD_ONE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X: center[0] <= cfg_data;
        CFG_CENTER_Y: center[1] <= cfg_data;
        CFG_CENTER_Z: center[2] <= cfg_data;
        CFG_RADIUS:   radius    <= cfg_data[RSI_RAD_W-1:0];
        default:      ;
      endcase
    end
  end

  // zero radius divides by one lsb
  assign rad_div = (radius == '0) ? RSI_RAD_W'(1) : radius;

  // global advance: everything moves unless a result waits
  logic adv;
  logic out_valid;

  assign adv       = !out_valid || hit.ready;
  assign ray.ready = adv;

  ray_t in_ray;

  assign in_ray.start = {ray.start_z, ray.start_y, ray.start_x};
  assign in_ray.dir   = {ray.dir_z, ray.dir_y, ray.dir_x};

  // quadratic terms and discriminant
  logic                  fr_valid;
  quad_t                 fr_side;
  logic [RSI_DISC_W-1:0] fr_disc;

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ray.valid),
    .in_ray    (in_ray),
    .center    (center),
    .radius    (radius),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_disc  (fr_disc)
  );

  // square root of the discriminant
  logic          sq_valid;
  logic [RW-1:0] sq_root;
  quad_t         sq_side;

  rsi_sqrt #(.SIDE_T(quad_t)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_rad    (fr_disc),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // root numerator, scaled for the distance divide
  logic             nm_valid;
  logic [NUM_W-1:0] nm_num [1];
  logic [PW-1:0]    nm_a;
  ray_side_t        nm_side;
  logic [RW+1:0]    num_raw;

  always_comb begin
    if (sq_side.h_neg && !sq_side.c_neg && !sq_side.c_zero) begin
      num_raw = (RW+2)'(sq_side.hm) - (RW+2)'(sq_root);
    end else if (sq_side.h_neg) begin
      num_raw = (RW+2)'(sq_side.hm) + (RW+2)'(sq_root);
    end else begin
      num_raw = (RW+2)'(sq_root) - (RW+2)'(sq_side.hm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (adv) begin
      nm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_num[0]     <= NUM_W'(num_raw) << FRAC_BITS;
      nm_a          <= sq_side.a;
      nm_side.hit   <= sq_side.hit;
      nm_side.start <= sq_side.start;
      nm_side.dir   <= sq_side.dir;
    end
  end

  // distance divide by a
  logic          dq_valid;
  logic [QW-1:0] dq_q   [1];
  logic          dq_sat [1];
  ray_side_t     dq_side;

  rsi_div #(
    .NUM_W (NUM_W),
    .DEN_W (PW),
    .Q_W   (QW),
    .LANES (1),
    .SIDE_T(ray_side_t)
  ) u_div_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (nm_valid),
    .in_num    (nm_num),
    .in_den    (nm_a),
    .in_side   (nm_side),
    .out_valid (dq_valid),
    .out_q     (dq_q),
    .out_sat   (dq_sat),
    .out_side  (dq_side)
  );

  // p1: distance and direction times distance
  logic                     p1_valid, p1_hit;
  fix_t                     p1_dist;
  vec3_t                    p1_start;
  logic signed [PW-1:0]     p1_prod [3];
  fix_t                     dist_val;

  assign dist_val = !dq_side.hit ? DIST_MISS :
                    dq_sat[0]    ? FIX_MAX   : fix_t'({1'b0, dq_q[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_hit   <= dq_side.hit;
      p1_dist  <= dist_val;
      p1_start <= dq_side.start;
      for (int i = 0; i < 3; i++) begin
        p1_prod[i] <= $signed(dq_side.dir[i]) * dist_val;
      end
    end
  end

  // p2: hit position
  logic  p2_valid, p2_hit;
  fix_t  p2_dist;
  vec3_t p2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_hit  <= p1_hit;
      p2_dist <= p1_dist;
      for (int i = 0; i < 3; i++) begin
        p2_pos[i] <= p1_hit ? sat32(66'($signed(p1_start[i])) + 66'(p1_prod[i] >>> FRAC_BITS))
                            : '0;
      end
    end
  end

  // p3: offset from the center, split into sign and scaled magnitude
  logic                       p3_valid;
  logic [NRM_W-1:0]           p3_num [3];
  norm_side_t                 p3_side;
  logic signed [RSI_DATA_W:0] diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (RSI_DATA_W+1)'($signed(p2_pos[i])) - (RSI_DATA_W+1)'($signed(center[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_side.hit      <= p2_hit;
      p3_side.hit_dist <= p2_dist;
      p3_side.pos      <= p2_pos;
      for (int i = 0; i < 3; i++) begin
        p3_side.neg[i] <= diff[i][RSI_DATA_W];
        p3_num[i]      <= NRM_W'(diff[i][RSI_DATA_W] ? -diff[i] : diff[i]) << FRAC_BITS;
      end
    end
  end

  // normal divide by the radius, three lanes
  logic          nd_valid;
  logic [QW-1:0] nd_q   [3];
  logic          nd_sat [3];
  norm_side_t    nd_side;

  rsi_div #(
    .NUM_W (NRM_W),
    .DEN_W (RSI_RAD_W),
    .Q_W   (QW),
    .LANES (3),
    .SIDE_T(norm_side_t)
  ) u_div_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (p3_valid),
    .in_num    (p3_num),
    .in_den    (rad_div),
    .in_side   (p3_side),
    .out_valid (nd_valid),
    .out_q     (nd_q),
    .out_sat   (nd_sat),
    .out_side  (nd_side)
  );

  // output register
  fix_t norm_val [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!nd_side.hit) begin
        norm_val[i] = '0;
      end else if (nd_side.neg[i]) begin
        norm_val[i] = nd_sat[i] ? FIX_MIN : -fix_t'({1'b0, nd_q[i]});
      end else begin
        norm_val[i] = nd_sat[i] ? FIX_MAX : fix_t'({1'b0, nd_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= nd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit.hit_found    <= nd_side.hit;
      hit.hit_distance <= nd_side.hit_dist;
      hit.pos_x        <= nd_side.pos[0];
      hit.pos_y        <= nd_side.pos[1];
      hit.pos_z        <= nd_side.pos[2];
      hit.norm_x       <= norm_val[0];
      hit.norm_y       <= norm_val[1];
      hit.norm_z       <= norm_val[2];
    end
  end

  assign hit.valid = out_valid;

endmodule

@@ rtl/core/rsi_checker.sv @@
// port-level checker for the intersection core, bound to the top level
module rsi_checker import rsi_pkg::*; #(
  parameter int FRAC_BITS = RSI_FRAC_BITS
) (
  input logic clk,
  input logic rst,
  input logic ray_ready,
  input logic hit_valid,
  input logic hit_ready,
  input logic hit_found,
  input fix_t hit_distance,
  input fix_t pos_x,
  input fix_t pos_y,
  input fix_t pos_z,
  input fix_t norm_x,
  input fix_t norm_y,
  input fix_t norm_z
);

  localparam fix_t DIST_MISS = -(fix_t'(1) <<< FRAC_BITS);

  // a stalled result holds its valid, hit flag, distance, pos_x and norm_x
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(hit_found) && $stable(hit_distance)
      && $stable(pos_x) && $stable(norm_x))
    else $error("stalled hit request changed");

  // no pending result means the input is open
  a_open: assert property (@(posedge clk) disable iff (rst)
    !hit_valid |-> ray_ready)
    else $error("ray request blocked with empty output");

  // a miss carries the fixed miss pattern
  a_miss: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_found |-> hit_distance == DIST_MISS && pos_x == '0 && pos_y == '0
      && pos_z == '0 && norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("miss result not cleared");

  // a hit lies ahead of the origin
  a_ahead: assert property (@(posedge clk) disable iff (rst)
    hit_valid && hit_found |-> !hit_distance[RSI_DATA_W-1])
    else $error("hit with negative distance");

endmodule

bind ray_sphere_intersect_core rsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rsi_checker (
  .clk          (clk),
  .rst          (rst),
  .ray_ready    (ray.ready),
  .hit_valid    (hit.valid),
  .hit_ready    (hit.ready),
  .hit_found    (hit.hit_found),
  .hit_distance (hit.hit_distance),
  .pos_x        (hit.pos_x),
  .pos_y        (hit.pos_y),
  .pos_z        (hit.pos_z),
  .norm_x       (hit.norm_x),
  .norm_y       (hit.norm_y),
  .norm_z       (hit.norm_z)
);
